### rtl/core/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared widths and stage payload types of the RGB/HSV color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvc_pkg;

  // Component width; full scale is 2^CB - 1, one hue turn is 2^CB.
  localparam int CB      = 16;
  // Remainder and divisor width of the hue and saturation dividers (6 * c).
  localparam int REM_W   = CB + 3;
  // Width of hue times six.
  localparam int H6_W    = CB + 3;
  // Number of divider steps, one quotient bit each.
  localparam int N_DIV   = CB;
  // Front stages ahead of the dividers.
  localparam int N_FRONT = 6;
  // All register stages, the output register included.
  localparam int N_STG   = N_FRONT + N_DIV + 1;

  localparam logic [CB-1:0] FULL = {CB{1'b1}};

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_t;

  // One long division in flight: partial remainder, numerator bits still to
  // bring down, divisor and the quotient bits gathered so far.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [CB-1:0]    lo;
    logic [REM_W-1:0] dvs;
    logic [CB-1:0]    quo;
  } div_t;

  // Data that rides along with the dividers.
  typedef struct packed {
    logic          cmd;
    logic          zero_chroma;
    logic          zero_max;
    logic [CB-1:0] r0;
    logic [CB-1:0] r1;
    logic [CB-1:0] r2;
  } side_t;

endpackage

`default_nettype wire

### rtl/core/hsvc_div_step.sv
// ----------------------------------------------------------------------------
// hsvc_div_step
// One restoring division step for the hue and saturation quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_div_step
  import hsvc_pkg::*;
(
  input  wire   clk,
  input  wire   en,
  input  div_t  hue_i,
  input  div_t  sat_i,
  input  side_t side_i,
  output div_t  hue_r,
  output div_t  sat_r,
  output side_t side_r
);

  div_t hue_nxt;
  div_t sat_nxt;

  function automatic div_t step(input div_t d);
    logic [REM_W:0] trial;
    logic           ge;
    div_t           o;
    trial = {d.rem, d.lo[CB-1]};
    ge    = (trial >= {1'b0, d.dvs});
    o     = d;
    o.rem = ge ? REM_W'(trial - {1'b0, d.dvs}) : trial[REM_W-1:0];
    o.lo  = {d.lo[CB-2:0], 1'b0};
    o.quo = {d.quo[CB-2:0], ge};
    return o;
  endfunction

  always_comb begin
    hue_nxt = step(hue_i);
    sat_nxt = step(sat_i);
  end

  // Advance only when the next stage can take this one.
  always_ff @(posedge clk) begin
    if (en) begin
      hue_r  <= hue_nxt;
      sat_r  <= sat_nxt;
      side_r <= side_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rgb_hsv_color_convert_core.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_convert_core
// Per-pixel RGB to HSV and HSV to RGB converter, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  ports                               direction  moves
//  -------  ----------------------------------  ---------  ------------------
//  input    in_valid in_stall in_command in_*   in         one pixel + command
//  result   out_valid out_stall out_*           out        one converted pixel
//
//  Throughput is one transaction per clock while out_stall is low; the path
//  runs through six front stages (the first loaded at the accepting edge),
//  sixteen one-bit divider steps (both quotients in parallel) and the output
//  register.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage moves forward when it is empty or its successor moves, so
//  bubbles collapse while out_stall is high and in_stall rises only when
//  every stage holds a transaction.
//
`default_nettype none

module rgb_hsv_color_convert_core
  import hsvc_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  input  wire           in_command,
  input  wire  [CB-1:0] in_red_or_hue,
  input  wire  [CB-1:0] in_green_or_sat,
  input  wire  [CB-1:0] in_blue_or_value,
  output logic          out_valid,
  input  wire           out_stall,
  output logic [CB-1:0] out_hue_or_red,
  output logic [CB-1:0] out_sat_or_green,
  output logic [CB-1:0] out_value_or_blue
);

  // --------------------------------------------------------------------------
  // Stage valid bits and advance chain
  // --------------------------------------------------------------------------
  logic [N_STG-1:0] v_r;
  logic [N_STG-1:0] v_nxt;
  logic [N_STG-1:0] adv;

  always_comb begin
    adv[N_STG-1] = !v_r[N_STG-1] || !out_stall;
    for (int k = N_STG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    for (int k = 0; k < N_STG; k++) begin
      if (adv[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[N_STG-1];

  // --------------------------------------------------------------------------
  // Stage 1: register the incoming transaction
  // --------------------------------------------------------------------------
  logic          s1_cmd_r;
  logic [CB-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_cmd_r <= in_command;
      s1_a_r   <= in_red_or_hue;
      s1_b_r   <= in_green_or_sat;
      s1_c_r   <= in_blue_or_value;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: max/min and the max channel (ties go red, green, blue);
  // hue times six for the sector split
  // --------------------------------------------------------------------------
  logic          s2_cmd_r;
  logic [CB-1:0] s2_a_r, s2_b_r, s2_c_r, s2_mx_r, s2_mn_r;
  max_sel_t      s2_sel_r;
  logic [H6_W-1:0] s2_h6_r;
  logic [CB-1:0] mx_w, mn_w;
  max_sel_t      sel_w;

  always_comb begin
    if (s1_a_r >= s1_b_r && s1_a_r >= s1_c_r) begin
      sel_w = MAX_RED;
      mx_w  = s1_a_r;
    end else if (s1_b_r >= s1_c_r) begin
      sel_w = MAX_GREEN;
      mx_w  = s1_b_r;
    end else begin
      sel_w = MAX_BLUE;
      mx_w  = s1_c_r;
    end
    mn_w = s1_a_r;
    if (s1_b_r < mn_w) mn_w = s1_b_r;
    if (s1_c_r < mn_w) mn_w = s1_c_r;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_cmd_r <= s1_cmd_r;
      s2_a_r   <= s1_a_r;
      s2_b_r   <= s1_b_r;
      s2_c_r   <= s1_c_r;
      s2_mx_r  <= mx_w;
      s2_mn_r  <= mn_w;
      s2_sel_r <= sel_w;
      s2_h6_r  <= (H6_W'(s1_a_r) << 2) + (H6_W'(s1_a_r) << 1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: chroma and hue numerator; s*f, s*(turn-f) and 1-s
  // --------------------------------------------------------------------------
  logic            s3_cmd_r;
  logic [CB-1:0]   s3_c_r, s3_mx_r, s3_oms_r, s3_v_r;
  logic [REM_W-1:0] s3_num_r;
  logic [2:0]      s3_sector_r;
  logic [2*CB-1:0] s3_sf_r, s3_sg_r;
  logic [CB-1:0]   chroma_w;
  logic signed [REM_W:0] num_w;
  logic signed [REM_W:0] ce_w;
  logic [CB:0]     tf_w;
  logic [2*CB:0]   sg_w;

  always_comb begin
    chroma_w = s2_mx_r - s2_mn_r;
    ce_w     = $signed({{(REM_W + 1 - CB){1'b0}}, chroma_w});
    case (s2_sel_r)
      MAX_RED:   num_w = $signed((REM_W + 1)'(s2_b_r)) - $signed((REM_W + 1)'(s2_c_r));
      MAX_GREEN: num_w = (ce_w <<< 1) + $signed((REM_W + 1)'(s2_c_r))
                         - $signed((REM_W + 1)'(s2_a_r));
      default:   num_w = (ce_w <<< 2) + $signed((REM_W + 1)'(s2_a_r))
                         - $signed((REM_W + 1)'(s2_b_r));
    endcase
    // Wrap a negative numerator into the turn.
    if (num_w < 0) begin
      num_w = num_w + (ce_w <<< 2) + (ce_w <<< 1);
    end
    tf_w = {1'b1, {CB{1'b0}}} - {1'b0, s2_h6_r[CB-1:0]};
    sg_w = (2 * CB + 1)'(s2_b_r) * (2 * CB + 1)'(tf_w);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_cmd_r    <= s2_cmd_r;
      s3_c_r      <= chroma_w;
      s3_mx_r     <= s2_mx_r;
      s3_num_r    <= num_w[REM_W-1:0];
      s3_sector_r <= s2_h6_r[H6_W-1:CB];
      s3_sf_r     <= (2 * CB)'(s2_b_r) * (2 * CB)'(s2_h6_r[CB-1:0]);
      s3_sg_r     <= sg_w[2*CB-1:0];
      s3_oms_r    <= FULL - s2_b_r;
      s3_v_r      <= s2_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: set up both divisions; 1 - s*f and 1 - s*(turn-f)
  // --------------------------------------------------------------------------
  logic          s4_cmd_r, s4_zc_r, s4_zm_r;
  logic [CB-1:0] s4_mx_r, s4_oms_r, s4_qs_r, s4_ts_r, s4_v_r;
  logic [2:0]    s4_sector_r;
  div_t          s4_hue_r, s4_sat_r;
  div_t          hue_init_w, sat_init_w;
  logic [2*CB-1:0] ns_w;

  always_comb begin
    // Saturation numerator c * FULL, divisor max.
    ns_w            = {s3_c_r, {CB{1'b0}}} - (2 * CB)'(s3_c_r);
    sat_init_w.rem  = REM_W'(ns_w[2*CB-1:CB]);
    sat_init_w.lo   = ns_w[CB-1:0];
    sat_init_w.dvs  = REM_W'(s3_mx_r);
    sat_init_w.quo  = '0;
    // Hue numerator num * turn, divisor 6 * c.
    hue_init_w.rem  = s3_num_r;
    hue_init_w.lo   = '0;
    hue_init_w.dvs  = (REM_W'(s3_c_r) << 2) + (REM_W'(s3_c_r) << 1);
    hue_init_w.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_cmd_r    <= s3_cmd_r;
      s4_zc_r     <= (s3_c_r == '0);
      s4_zm_r     <= (s3_mx_r == '0);
      s4_mx_r     <= s3_mx_r;
      s4_hue_r    <= hue_init_w;
      s4_sat_r    <= sat_init_w;
      s4_oms_r    <= s3_oms_r;
      s4_qs_r     <= FULL - s3_sf_r[2*CB-1:CB];
      s4_ts_r     <= FULL - s3_sg_r[2*CB-1:CB];
      s4_v_r      <= s3_v_r;
      s4_sector_r <= s3_sector_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: v times each factor
  // --------------------------------------------------------------------------
  logic            s5_cmd_r, s5_zc_r, s5_zm_r;
  logic [CB-1:0]   s5_mx_r, s5_v_r;
  logic [2:0]      s5_sector_r;
  div_t            s5_hue_r, s5_sat_r;
  logic [2*CB-1:0] s5_pv_r, s5_qv_r, s5_tv_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_cmd_r    <= s4_cmd_r;
      s5_zc_r     <= s4_zc_r;
      s5_zm_r     <= s4_zm_r;
      s5_mx_r     <= s4_mx_r;
      s5_v_r      <= s4_v_r;
      s5_sector_r <= s4_sector_r;
      s5_hue_r    <= s4_hue_r;
      s5_sat_r    <= s4_sat_r;
      s5_pv_r     <= (2 * CB)'(s4_v_r) * (2 * CB)'(s4_oms_r);
      s5_qv_r     <= (2 * CB)'(s4_v_r) * (2 * CB)'(s4_qs_r);
      s5_tv_r     <= (2 * CB)'(s4_v_r) * (2 * CB)'(s4_ts_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: divide by full scale, pick the sector order
  // --------------------------------------------------------------------------
  // x = q1 * 2^CB + lo = q1 * FULL + (q1 + lo); with x <= FULL^2 the remainder
  // term stays below 2 * FULL, so one correction is enough.
  function automatic logic [CB-1:0] div_full(input logic [2*CB-1:0] x);
    logic [CB:0] r;
    r = {1'b0, x[CB-1:0]} + {1'b0, x[2*CB-1:CB]};
    return x[2*CB-1:CB] + CB'(r >= {1'b0, FULL});
  endfunction

  div_t          s6_hue_r, s6_sat_r;
  side_t         s6_side_r;
  side_t         side_w;
  logic [CB-1:0] p_w, q_w, t_w;

  always_comb begin
    p_w                = div_full(s5_pv_r);
    q_w                = div_full(s5_qv_r);
    t_w                = div_full(s5_tv_r);
    side_w.cmd         = s5_cmd_r;
    side_w.zero_chroma = s5_zc_r;
    side_w.zero_max    = s5_zm_r;
    if (s5_cmd_r) begin
      case (s5_sector_r)
        3'd0:    begin side_w.r0 = s5_v_r; side_w.r1 = t_w;    side_w.r2 = p_w;    end
        3'd1:    begin side_w.r0 = q_w;    side_w.r1 = s5_v_r; side_w.r2 = p_w;    end
        3'd2:    begin side_w.r0 = p_w;    side_w.r1 = s5_v_r; side_w.r2 = t_w;    end
        3'd3:    begin side_w.r0 = p_w;    side_w.r1 = q_w;    side_w.r2 = s5_v_r; end
        3'd4:    begin side_w.r0 = t_w;    side_w.r1 = p_w;    side_w.r2 = s5_v_r; end
        default: begin side_w.r0 = s5_v_r; side_w.r1 = p_w;    side_w.r2 = q_w;    end
      endcase
    end else begin
      // Hue and saturation come out of the dividers; carry value.
      side_w.r0 = '0;
      side_w.r1 = '0;
      side_w.r2 = s5_mx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_hue_r  <= s5_hue_r;
      s6_sat_r  <= s5_sat_r;
      s6_side_r <= side_w;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: one quotient bit per stage for hue and saturation
  // --------------------------------------------------------------------------
  div_t  dh_in [N_DIV];
  div_t  ds_in [N_DIV];
  side_t sd_in [N_DIV];
  div_t  dh_q  [N_DIV];
  div_t  ds_q  [N_DIV];
  side_t sd_q  [N_DIV];

  for (genvar i = 0; i < N_DIV; i++) begin : g_div
    if (i == 0) begin : g_first
      assign dh_in[i] = s6_hue_r;
      assign ds_in[i] = s6_sat_r;
      assign sd_in[i] = s6_side_r;
    end else begin : g_next
      assign dh_in[i] = dh_q[i-1];
      assign ds_in[i] = ds_q[i-1];
      assign sd_in[i] = sd_q[i-1];
    end

    hsvc_div_step u_step (
      .clk    (clk),
      .en     (adv[N_FRONT + i]),
      .hue_i  (dh_in[i]),
      .sat_i  (ds_in[i]),
      .side_i (sd_in[i]),
      .hue_r  (dh_q[i]),
      .sat_r  (ds_q[i]),
      .side_r (sd_q[i])
    );
  end

  // --------------------------------------------------------------------------
  // Output register: drop the quotients on zero chroma or zero maximum
  // --------------------------------------------------------------------------
  side_t         last_w;
  logic          out_cmd_r;
  logic [CB-1:0] o0_nxt, o1_nxt, o2_nxt;

  always_comb begin
    last_w = sd_q[N_DIV-1];
    if (last_w.cmd) begin
      o0_nxt = last_w.r0;
      o1_nxt = last_w.r1;
    end else begin
      o0_nxt = last_w.zero_chroma ? '0 : dh_q[N_DIV-1].quo;
      o1_nxt = last_w.zero_max    ? '0 : ds_q[N_DIV-1].quo;
    end
    o2_nxt = last_w.r2;
  end

  always_ff @(posedge clk) begin
    if (adv[N_STG-1]) begin
      out_cmd_r         <= last_w.cmd;
      out_hue_or_red    <= o0_nxt;
      out_sat_or_green  <= o1_nxt;
      out_value_or_blue <= o2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An open output never backs up the input.
  a_no_stall_when_open : assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is open");

  // An empty pipeline always takes a transaction.
  a_empty_takes : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0) |-> !in_stall)
    else $error("empty pipeline stalls input");

  // A held front stage keeps its transaction.
  a_front_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !adv[0]) |=> v_r[0])
    else $error("front stage lost a transaction");

  // Black converts to zero hue and zero saturation.
  a_black_hsv : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_cmd_r && out_value_or_blue == '0)
      |-> (out_hue_or_red == '0 && out_sat_or_green == '0))
    else $error("black pixel gave nonzero hue or saturation");

endmodule

`default_nettype wire
